/* src/task_delay_timeout_queue_unit_assert.svh */
// Assertion macros shared by the timer queue modules
`ifndef TASK_DELAY_TIMEOUT_QUEUE_UNIT_ASSERT_SVH
`define TASK_DELAY_TIMEOUT_QUEUE_UNIT_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define TDTQ_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TDTQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle
`define TDTQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/tdtq_pkg.sv */
// Shared types and constants of the timer queue
package tdtq_pkg;
    localparam int TASK_SLOTS = 16;
    localparam int DELAY_BITS = 32;
    localparam int SLOT_W     = 4;
    localparam int IN_DELAY_W = 32;
    localparam int KIND_W     = 2;
    localparam int RANK_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEC,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;     // apply the request on the input ports
        logic dec;      // tick: lower counts unless one is already zero, rewind scan pointer
        logic wake;     // emit the slot under the pointer and drop it
        logic adv;      // step the pointer to the next rank
    } tdtq_cmd_t;

    typedef struct packed {
        logic hit;      // slot under the pointer is due
        logic done;     // pointer has passed every queued rank
        logic out_free; // output register can take a request
    } tdtq_stat_t;
endpackage

/* src/task_delay_timeout_queue_unit.sv */
// Top level: task sleep and timeout queue with per-slot tick counters
// Insert, remove and unused-kind requests leave the controller idle; s_ready stays high.
// A tick is taken in idle and then runs a decrement step, a scan over the queued ranks
// (at most TASK_SLOTS) and a closing step back to idle.
// Releases leave through the output register; output back-pressure holds the scan.
// aresetn (synchronous, active low) empties the queue and drops any pending result.
module task_delay_timeout_queue_unit
    import tdtq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [SLOT_W-1:0]     s_task_slot,
    input  logic [IN_DELAY_W-1:0] s_delay,
    input  logic                  s_waits_on_object,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_woken_task,
    output logic                  m_timed_out,
    output logic                  m_last
);
    tdtq_cmd_t  cmd;
    tdtq_stat_t stat;

    tdtq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tdtq_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_kind            (s_kind),
        .s_task_slot       (s_task_slot),
        .s_delay           (s_delay),
        .s_waits_on_object (s_waits_on_object),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_woken_task      (m_woken_task),
        .m_timed_out       (m_timed_out),
        .m_last            (m_last)
    );
endmodule

/* src/tdtq_dp.sv */
// Datapath: per-slot counters, insertion ranks, release scan and output register
module tdtq_dp
    import tdtq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tdtq_cmd_t             cmd,
    output tdtq_stat_t            stat,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [SLOT_W-1:0]     s_task_slot,
    input  logic [IN_DELAY_W-1:0] s_delay,
    input  logic                  s_waits_on_object,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_woken_task,
    output logic                  m_timed_out,
    output logic                  m_last
);
    `include "task_delay_timeout_queue_unit_assert.svh"

    logic [DELAY_BITS-1:0] rem_reg   [TASK_SLOTS];
    logic [DELAY_BITS-1:0] rem_next  [TASK_SLOTS];
    logic [RANK_W-1:0]     rank_reg  [TASK_SLOTS];
    logic [RANK_W-1:0]     rank_next [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] queued_reg, queued_next;
    logic [TASK_SLOTS-1:0] objw_reg, objw_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic                  m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]     woken_reg, woken_next;
    logic                  tout_reg, tout_next;
    logic                  last_reg, last_next;

    logic [TASK_SLOTS-1:0] slot_vec, zero_vec, sel_vec, drop_vec;
    logic [RANK_W-1:0]     drop_rank, slot_rank;
    logic                  drop_en, is_ins, is_rem, slot_queued;
    logic [SLOT_W-1:0]     sel_idx;

    always_comb begin
        slot_rank = '0;
        sel_idx   = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_vec[i] = (int'(s_task_slot) == i);
            zero_vec[i] = queued_reg[i] && (rem_reg[i] == '0);
            sel_vec[i]  = zero_vec[i] && (rank_reg[i] == ptr_reg[RANK_W-1:0]);
            if (slot_vec[i]) begin
                slot_rank = rank_reg[i];
            end
            if (sel_vec[i]) begin
                sel_idx = SLOT_W'(i);
            end
        end
        slot_queued = |(slot_vec & queued_reg);
    end

    assign stat.hit      = |sel_vec;
    assign stat.done     = (ptr_reg >= count_reg);
    assign stat.out_free = !m_valid_reg || m_ready;

    assign is_ins = cmd.load && (s_kind == KIND_INSERT) && (|slot_vec) && !slot_queued;
    assign is_rem = cmd.load && (s_kind == KIND_REMOVE) && slot_queued;

    always_comb begin
        drop_en   = is_rem || cmd.wake;
        drop_vec  = cmd.wake ? sel_vec : slot_vec;
        drop_rank = cmd.wake ? ptr_reg[RANK_W-1:0] : slot_rank;
    end

    always_comb begin
        queued_next = queued_reg;
        objw_next   = objw_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            rem_next[i]  = rem_reg[i];
            rank_next[i] = rank_reg[i];
        end

        // Park the pointer on each accepted request so it never runs past the count
        if (cmd.load) begin
            ptr_next = '0;
        end

        if (is_ins) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (slot_vec[i]) begin
                    rem_next[i]    = DELAY_BITS'(s_delay);
                    rank_next[i]   = count_reg[RANK_W-1:0];
                    queued_next[i] = 1'b1;
                    objw_next[i]   = s_waits_on_object;
                end
            end
            count_next = count_reg + 1'b1;
        end

        // Close the gap left by the dropped slot
        if (drop_en) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (drop_vec[i]) begin
                    rem_next[i]    = '0;
                    rank_next[i]   = '0;
                    queued_next[i] = 1'b0;
                    objw_next[i]   = 1'b0;
                end else if (queued_reg[i] && rank_reg[i] > drop_rank) begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            count_next = count_reg - 1'b1;
        end

        if (cmd.dec) begin
            ptr_next = '0;
            if (!(|zero_vec)) begin
                for (int i = 0; i < TASK_SLOTS; i++) begin
                    if (queued_reg[i]) begin
                        rem_next[i] = rem_reg[i] - 1'b1;
                    end
                end
            end
        end

        if (cmd.adv) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        woken_next   = woken_reg;
        tout_next    = tout_reg;
        last_next    = last_reg;
        if (cmd.wake) begin
            m_valid_next = 1'b1;
            woken_next   = sel_idx;
            tout_next    = |(sel_vec & objw_reg);
            last_next    = ((zero_vec & ~sel_vec) == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queued_reg  <= '0;
            objw_reg    <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                rem_reg[i]  <= '0;
                rank_reg[i] <= '0;
            end
        end else begin
            queued_reg  <= queued_next;
            objw_reg    <= objw_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                rem_reg[i]  <= rem_next[i];
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        woken_reg <= woken_next;
        tout_reg  <= tout_next;
        last_reg  <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_woken_task = woken_reg;
    assign m_timed_out  = tout_reg;
    assign m_last       = last_reg;

    `TDTQ_ASSERT_ALWAYS(a_count_matches, aclk, aresetn, $countones(queued_reg) == count_reg, "queue count out of step with queued slots")
    `TDTQ_ASSERT_ALWAYS(a_ptr_in_range, aclk, aresetn, ptr_reg <= count_reg, "scan pointer beyond queued count")
    `TDTQ_ASSERT_IMPL(a_release_onehot, aclk, aresetn, cmd.wake, $onehot(sel_vec), "release without a single due slot")
endmodule

/* src/tdtq_ctrl.sv */
// Controller: sequences request intake, tick decrement and the release scan
module tdtq_ctrl
    import tdtq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic [KIND_W-1:0] s_kind,
    output logic              s_ready,
    input  tdtq_stat_t        stat,
    output tdtq_cmd_t         cmd
);
    `include "task_delay_timeout_queue_unit_assert.svh"

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (s_kind == KIND_TICK) begin
                        state_next = ST_DEC;
                    end
                end
            end
            ST_DEC: begin
                cmd.dec    = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // Hold on a due slot until the output register frees up
                if (stat.done) begin
                    state_next = ST_IDLE;
                end else if (stat.hit) begin
                    cmd.wake = stat.out_free;
                end else begin
                    cmd.adv = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TDTQ_ASSERT_NEXT(a_tick_decs, aclk, aresetn, cmd.load && s_kind == KIND_TICK, cmd.dec, "tick not followed by decrement")
    `TDTQ_ASSERT_IMPL(a_release_ok, aclk, aresetn, cmd.wake, stat.hit && stat.out_free && !stat.done, "release without due slot or space")
    `TDTQ_ASSERT_IMPL(a_busy_no_load, aclk, aresetn, state_reg != ST_IDLE, !s_ready && !cmd.load, "request taken while busy")
endmodule

/* bench/tb_task_delay_timeout_queue_unit.sv */
// Self-checking testbench for the task sleep and timeout queue
`timescale 1ns / 100ps

module tb_task_delay_timeout_queue_unit;
    import tdtq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int EXP_DEPTH   = 1024;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              timed_out;
        logic              last;
    } release_t;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [SLOT_W-1:0]     slot;
        logic [IN_DELAY_W-1:0] delay;
        logic                  wait_obj;
        int                    n_rel;   // -1: use predictor, else typed-in release count
        logic [SLOT_W-1:0]     rel_slot;
        logic                  rel_to;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [KIND_W-1:0]     s_kind;
    logic [SLOT_W-1:0]     s_task_slot;
    logic [IN_DELAY_W-1:0] s_delay;
    logic                  s_waits_on_object;
    logic                  m_valid;
    logic                  m_ready;
    logic [SLOT_W-1:0]     m_woken_task;
    logic                  m_timed_out;
    logic                  m_last;

    // predictor state
    logic [DELAY_BITS-1:0] ticks_left [TASK_SLOTS];
    logic                  in_queue   [TASK_SLOTS];
    logic                  on_object  [TASK_SLOTS];
    int                    age_rank   [TASK_SLOTS];
    int                    n_queued;

    // expected releases, written by the sender and read by the checker
    release_t exp_buf [EXP_DEPTH];
    int       exp_wr;
    int       exp_rd;
    int       errors;
    int       cycles;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       hold_off;
    int       hold_len;

    task_delay_timeout_queue_unit DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    function automatic void unlink_slot(input int s);
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (in_queue[i] && i != s && age_rank[i] > age_rank[s]) age_rank[i]--;
        end
        in_queue[s]   = 1'b0;
        on_object[s]  = 1'b0;
        ticks_left[s] = '0;
        age_rank[s]   = 0;
        if (n_queued > 0) n_queued--;
    endfunction

    // apply one request to the predictor, queue the releases it causes
    function automatic int predict_timer(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                                         input logic [IN_DELAY_W-1:0] delay, input logic wait_obj);
        int  n;
        bit  any_q;
        bit  any_zero;
        int  first;
        n = 0;
        any_q = 0;
        any_zero = 0;
        first = exp_wr;
        if (kind == KIND_INSERT) begin
            if (!in_queue[slot]) begin
                in_queue[slot]   = 1'b1;
                ticks_left[slot] = delay[DELAY_BITS-1:0];
                on_object[slot]  = wait_obj;
                age_rank[slot]   = n_queued;
                n_queued++;
            end
        end else if (kind == KIND_REMOVE) begin
            if (in_queue[slot]) unlink_slot(slot);
        end else if (kind == KIND_TICK) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                if (in_queue[i]) begin
                    any_q = 1;
                    if (ticks_left[i] == 0) any_zero = 1;
                end
            end
            if (any_q) begin
                if (!any_zero) begin
                    for (int i = 0; i < TASK_SLOTS; i++) if (in_queue[i]) ticks_left[i]--;
                end
                for (int r = 0; r < TASK_SLOTS; r++) begin
                    for (int i = 0; i < TASK_SLOTS; i++) begin
                        if (in_queue[i] && age_rank[i] == r && ticks_left[i] == 0) begin
                            exp_buf[exp_wr % EXP_DEPTH] = '{slot: i[SLOT_W-1:0],
                                timed_out: on_object[i], last: 1'b0};
                            exp_wr++;
                            n++;
                        end
                    end
                end
                for (int r = TASK_SLOTS - 1; r >= 0; r--) begin
                    for (int i = 0; i < TASK_SLOTS; i++) begin
                        if (in_queue[i] && age_rank[i] == r && ticks_left[i] == 0) begin
                            unlink_slot(i);
                            break;
                        end
                    end
                end
                if (n > 0) exp_buf[(first + n - 1) % EXP_DEPTH].last = 1'b1;
            end
        end
        return n;
    endfunction

    // returns at the rising edge that takes the request, with s_valid still high
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                                input logic [IN_DELAY_W-1:0] delay, input logic wait_obj);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_kind            <= kind;
        s_task_slot       <= slot;
        s_delay           <= delay;
        s_waits_on_object <= wait_obj;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        void'(predict_timer(kind, slot, delay, wait_obj));
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge aclk);
        repeat (TASK_SLOTS + 8) @(negedge aclk);
    endtask

    // random request, mostly inserts and ticks with small delays
    task automatic random_request;
        int pick;
        logic [IN_DELAY_W-1:0] d;
        logic [SLOT_W-1:0]     s;
        logic                  w;
        pick = $urandom_range(99);
        s = SLOT_W'($urandom_range(15));
        w = 1'($urandom_range(1));
        case ($urandom_range(9))
            0:       d = $urandom;
            1:       d = {1'($urandom_range(1)), 29'd0, 2'($urandom_range(3))};
            default: d = $urandom_range(6);
        endcase
        if (pick < 45)      send_request(KIND_INSERT, s, d, w);
        else if (pick < 55) send_request(KIND_REMOVE, s, d, w);
        else if (pick < 97) send_request(KIND_TICK, s, d, w);
        else                send_request(KIND_UNUSED, s, d, w);
    endtask

    // receiver: random stall, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(negedge aclk);
                hold_off = 0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // check each release against the oldest expectation
    always @(posedge aclk) begin
        release_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("unexpected release, slot", m_woken_task, -1);
            end else begin
                want = exp_buf[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_woken_task !== want.slot) report_mismatch("woken_task", m_woken_task, want.slot);
                if (m_timed_out !== want.timed_out)
                    report_mismatch("timed_out", m_timed_out, want.timed_out);
                if (m_last !== want.last) report_mismatch("last", m_last, want.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("task_delay_timeout_queue_unit test failed");
            $finish;
        end
    end

    initial begin
        row_t rows[$];
        int   n;
        int   mark;
        errors = 0;
        cycles = 0;
        exp_wr = 0;
        exp_rd = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        hold_len = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_TICK;
        s_task_slot = '0;
        s_delay = '0;
        s_waits_on_object = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            ticks_left[i] = '0;
            in_queue[i] = 1'b0;
            on_object[i] = 1'b0;
            age_rank[i] = 0;
        end
        n_queued = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed table
        rows = '{
            '{KIND_TICK,   4'd0,  32'd0, 1'b0, 0, 4'd0, 1'b0},          // tick on empty queue
            '{KIND_INSERT, 4'd15, 32'd0, 1'b1, 0, 4'd0, 1'b0},          // zero delay
            '{KIND_TICK,   4'd0,  32'd0, 1'b0, 1, 4'd15, 1'b1},
            '{KIND_INSERT, 4'd0,  32'd1, 1'b0, 0, 4'd0, 1'b0},
            '{KIND_INSERT, 4'd0,  32'd9, 1'b1, 0, 4'd0, 1'b0},          // double insert
            '{KIND_TICK,   4'd0,  32'd0, 1'b0, 1, 4'd0, 1'b0},
            '{KIND_REMOVE, 4'd3,  32'd0, 1'b0, 0, 4'd0, 1'b0},          // remove of absent slot
            '{KIND_UNUSED, 4'd1,  32'd0, 1'b1, 0, 4'd0, 1'b0},          // unused kind
            '{KIND_INSERT, 4'd5,  32'd2, 1'b1, -1, 4'd0, 1'b0},         // equal deadlines
            '{KIND_INSERT, 4'd2,  32'd2, 1'b0, -1, 4'd0, 1'b0},
            '{KIND_INSERT, 4'd9,  32'd3, 1'b1, -1, 4'd0, 1'b0},
            '{KIND_INSERT, 4'd7,  32'hFFFF_FFFF, 1'b1, -1, 4'd0, 1'b0}, // largest delay
            '{KIND_TICK,   4'd0,  32'd0, 1'b0, -1, 4'd0, 1'b0},
            '{KIND_REMOVE, 4'd9,  32'd0, 1'b0, -1, 4'd0, 1'b0},
            '{KIND_TICK,   4'd0,  32'd0, 1'b0, -1, 4'd0, 1'b0},
            '{KIND_TICK,   4'd0,  32'd0, 1'b0, -1, 4'd0, 1'b0},
            '{KIND_REMOVE, 4'd7,  32'd0, 1'b0, -1, 4'd0, 1'b0},
            '{KIND_TICK,   4'hA,  32'hFFFF_FFFF, 1'b1, -1, 4'd0, 1'b0}
        };
        foreach (rows[k]) begin
            if (rows[k].n_rel >= 0) begin
                drain();
                mark = exp_wr;
                n = predict_timer(rows[k].kind, rows[k].slot, rows[k].delay, rows[k].wait_obj);
                if (n != rows[k].n_rel) report_mismatch("predicted release count", n, rows[k].n_rel);
                if (n == 1 && exp_buf[mark % EXP_DEPTH].slot != rows[k].rel_slot)
                    report_mismatch("predicted slot", exp_buf[mark % EXP_DEPTH].slot,
                                    rows[k].rel_slot);
                // keep the state update, expect the typed-in releases instead
                exp_wr = mark;
                s_valid           <= 1'b1;
                s_kind            <= rows[k].kind;
                s_task_slot       <= rows[k].slot;
                s_delay           <= rows[k].delay;
                s_waits_on_object <= rows[k].wait_obj;
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                for (int j = 0; j < rows[k].n_rel; j++) begin
                    exp_buf[exp_wr % EXP_DEPTH] = '{slot: rows[k].rel_slot,
                        timed_out: rows[k].rel_to, last: 1'b1};
                    exp_wr++;
                end
            end else begin
                send_request(rows[k].kind, rows[k].slot, rows[k].delay, rows[k].wait_obj);
            end
        end
        drain();

        // fill every slot with equal deadlines, then hold the receiver off
        for (int i = 0; i < TASK_SLOTS; i++)
            send_request(KIND_INSERT, SLOT_W'(15 - i), 32'd1, i[0]);
        hold_len = 300;
        hold_off = 1;
        for (int j = 0; j < 6; j++) send_request(KIND_TICK, 4'd0, 32'd0, 1'b0);
        for (int i = 0; i < 8; i++)
            send_request(KIND_INSERT, SLOT_W'($urandom_range(15)), 32'd0, 1'b1);
        send_request(KIND_TICK, 4'd0, 32'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 63 : (phase == 3) ? 33 : 0;
            recv_stall_pct = (phase == 2) ? 63 : (phase == 3) ? 33 : 0;
            repeat (90) random_request();
        end
        drain();
        repeat (40) @(negedge aclk);

        if (errors == 0 && exp_wr == exp_rd) begin
            $display("task_delay_timeout_queue_unit test passed");
        end else begin
            $display("task_delay_timeout_queue_unit test failed");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/tdtq_pkg.sv
src/tdtq_dp.sv
src/tdtq_ctrl.sv
src/task_delay_timeout_queue_unit.sv
bench/tb_task_delay_timeout_queue_unit.sv
